// ===== hdl/convex_polygon_containment_defines.svh =====
// assertion macros for the convex polygon containment block
// expects clk and arst_n in the scope where the macros are used
`ifndef CONVEX_POLYGON_CONTAINMENT_DEFINES_SVH
`define CONVEX_POLYGON_CONTAINMENT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define CPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cpc_pkg.sv =====
// shared constants, types and helpers for the convex polygon containment block
// no dependencies
package cpc_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int COORD_WIDTH  = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_WIDTH + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	typedef logic [1:0] side_t;
	localparam side_t SIDE_BELOW = 2'd0;
	localparam side_t SIDE_ABOVE = 2'd1;
	localparam side_t SIDE_ON    = 2'd2;
	localparam side_t SIDE_NONE  = 2'd3;

	typedef logic [1:0] action_t;
	localparam action_t ACT_CLEAR = 2'd0;
	localparam action_t ACT_ADD   = 2'd1;
	localparam action_t ACT_QUERY = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// tag that travels with each side test through the shared unit
	typedef struct packed {
		logic             vld;
		logic             keep;
		logic             last;
		logic [IDX_W-1:0] idx;
	} side_tag_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		coord_t           x;
		coord_t           y;
	} vm_wr_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} vm_rd_t;

	// following vertex around the polygon
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] nx;
		nx = {1'b0, i} + CNT_W'(1);
		if (nx >= cnt) begin
			return '0;
		end
		return nx[IDX_W-1:0];
	endfunction

endpackage

// ===== hdl/cpc_vertex_mem.sv =====
// vertex coordinate store: one write port, two registered read ports
// depends on cpc_pkg
module cpc_vertex_mem (
	input  logic                           clk,
	input  cpc_pkg::vm_wr_t                wr,
	input  logic [cpc_pkg::IDX_W-1:0]      ra_addr,
	input  logic [cpc_pkg::IDX_W-1:0]      rb_addr,
	output cpc_pkg::vm_rd_t                rd
);
	import cpc_pkg::*;

	coord_t mem_x [MAX_VERTICES];
	coord_t mem_y [MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_x[wr.addr] <= wr.x;
			mem_y[wr.addr] <= wr.y;
		end
	end

	always_ff @(posedge clk) begin
		rd.ax <= mem_x[ra_addr];
		rd.ay <= mem_y[ra_addr];
		rd.bx <= mem_x[rb_addr];
		rd.by <= mem_y[rb_addr];
	end

endmodule

// ===== hdl/cpc_side_unit.sv =====
// shared side test: which side of edge (x1,y1)-(x2,y2) the point (x3,y3) lies on
// three pipeline stages, exact cross-product sign; depends on cpc_pkg
module cpc_side_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpc_pkg::side_tag_t   tag_in,
	input  cpc_pkg::coord_t      x1,
	input  cpc_pkg::coord_t      y1,
	input  cpc_pkg::coord_t      x2,
	input  cpc_pkg::coord_t      y2,
	input  cpc_pkg::coord_t      x3,
	input  cpc_pkg::coord_t      y3,
	output cpc_pkg::side_tag_t   tag_out,
	output cpc_pkg::side_t       side
);
	import cpc_pkg::*;

	logic signed [DIFF_W-1:0] run_d, rise_d, dx_d, dy_d;
	side_t                    vcode_d;

	logic signed [DIFF_W-1:0] run_s1, rise_s1, dx_s1, dy_s1;
	logic                     vert_s1;
	side_t                    vcode_s1;
	side_tag_t                tag_s1;

	logic signed [PROD_W-1:0] p_d, q_d;
	logic signed [PROD_W-1:0] p_s2, q_s2;
	logic                     vert_s2, neg_s2;
	side_t                    vcode_s2;
	side_tag_t                tag_s2;

	logic signed [PROD_W:0]   diff_d;
	side_t                    code_d;
	side_t                    side_s3;
	side_tag_t                tag_s3;

	assign run_d  = DIFF_W'(x2) - DIFF_W'(x1);
	assign rise_d = DIFF_W'(y2) - DIFF_W'(y1);
	assign dx_d   = DIFF_W'(x3) - DIFF_W'(x1);
	assign dy_d   = DIFF_W'(y3) - DIFF_W'(y1);

	// vertical and zero-length edges
	always_comb begin
		if (y1 == y2) begin
			vcode_d = SIDE_ON;
		end else if (x3 > x1) begin
			vcode_d = SIDE_BELOW;
		end else if (x3 < x1) begin
			vcode_d = SIDE_ABOVE;
		end else begin
			vcode_d = SIDE_ON;
		end
	end

	always_ff @(posedge clk) begin
		run_s1   <= run_d;
		rise_s1  <= rise_d;
		dx_s1    <= dx_d;
		dy_s1    <= dy_d;
		vert_s1  <= (x1 == x2);
		vcode_s1 <= vcode_d;
	end

	// 17-bit signed operands, sign-extended to the product width
	assign p_d = PROD_W'(rise_s1) * PROD_W'(dx_s1);
	assign q_d = PROD_W'(dy_s1) * PROD_W'(run_s1);

	always_ff @(posedge clk) begin
		p_s2     <= p_d;
		q_s2     <= q_d;
		vert_s2  <= vert_s1;
		neg_s2   <= run_s1[DIFF_W-1];
		vcode_s2 <= vcode_s1;
	end

	// sign of (line y - point y) * run, flipped when the edge runs leftwards
	assign diff_d = (PROD_W+1)'(p_s2) - (PROD_W+1)'(q_s2);

	always_comb begin
		if (vert_s2) begin
			code_d = vcode_s2;
		end else if (diff_d == '0) begin
			code_d = SIDE_ON;
		end else if (diff_d[PROD_W] ^ neg_s2) begin
			code_d = SIDE_ABOVE;
		end else begin
			code_d = SIDE_BELOW;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= code_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign tag_out = tag_s3;
	assign side    = side_s3;

endmodule

// ===== hdl/convex_polygon_containment.sv =====
// convex polygon containment: sequencer, edge side store and flags
// depends on cpc_pkg, cpc_vertex_mem and cpc_side_unit
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+---------------------
//  command  | action, coord_x, coord_y, recheck                | start && !busy
//  result   | answer, convex, vertex_count, full_error         | done, one cycle
//
// clear, unused action codes, refused adds, unchecked adds, checked adds that leave
// fewer than three vertices and queries without a convex polygon: result next cycle.
// query: one side test per vertex, one per cycle through the side unit.
// checked add: each edge loads its endpoints from the vertex store, then streams
// every vertex through the three-stage side unit.
// arst_n clears the count and convex flag; the stores need no clearing pass.
// busy stays high while an item is in work; results cannot be held off.
module convex_polygon_containment (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic [cpc_pkg::COORD_WIDTH-1:0]   coord_x,
	input  logic [cpc_pkg::COORD_WIDTH-1:0]   coord_y,
	input  logic                              recheck,
	output logic                              done,
	output logic                              answer,
	output logic                              convex,
	output logic [cpc_pkg::CNT_W-1:0]         vertex_count,
	output logic                              full_error
);
	import cpc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_EDGE_RD = 7'b0000010,
		S_EDGE_LD = 7'b0000100,
		S_STREAM  = 7'b0001000,
		S_DRAIN   = 7'b0010000,
		S_QUERY   = 7'b0100000,
		S_QDRAIN  = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             convex_q;
	logic             done_q, answer_q, full_q;
	logic [IDX_W-1:0] edge_q, ptr_q;
	logic             ok_q, fresh_q, fail_q, qmode_q;
	side_t            code_q;
	coord_t           ex1_q, ey1_q, ex2_q, ey2_q, px_q, py_q;
	side_tag_t        issue_q;

	side_t            edge_side [MAX_VERTICES];

	logic             accept;
	logic             store_full;
	logic [CNT_W-1:0] count_inc;
	vm_wr_t           wr;
	vm_rd_t           rd;
	logic [IDX_W-1:0] ra_addr, rb_addr;
	logic [IDX_W-1:0] edge_nx, ptr_nx;
	side_tag_t        issue_d, res_tag;
	side_t            res_side;
	side_t            code_n;
	logic             fresh_n, fail_n, ok_n;
	logic             res_last;
	logic             es_we;
	logic [IDX_W-1:0] es_addr;
	side_t            es_data;
	coord_t           ux1, uy1, ux2, uy2, ux3, uy3;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign store_full = (count_q >= CNT_W'(MAX_VERTICES));
	assign count_inc  = count_q + CNT_W'(1);
	assign edge_nx    = next_idx(edge_q, count_q);
	assign ptr_nx     = next_idx(ptr_q, count_q);

	assign wr.en   = accept && (action == ACT_ADD) && !store_full;
	assign wr.addr = count_q[IDX_W-1:0];
	assign wr.x    = coord_x;
	assign wr.y    = coord_y;

	always_comb begin
		ra_addr = ptr_q;
		rb_addr = edge_nx;
		case (state_q)
			S_EDGE_RD: begin
				ra_addr = edge_q;
				rb_addr = edge_nx;
			end
			S_QUERY: begin
				ra_addr = ptr_q;
				rb_addr = ptr_nx;
			end
			default: begin
				ra_addr = ptr_q;
				rb_addr = edge_nx;
			end
		endcase
	end

	cpc_vertex_mem u_vmem (
		.clk     (clk),
		.wr      (wr),
		.ra_addr (ra_addr),
		.rb_addr (rb_addr),
		.rd      (rd)
	);

	// issue one side test per cycle while streaming; tag lines up with read data
	always_comb begin
		issue_d.vld  = (state_q == S_STREAM) || (state_q == S_QUERY);
		issue_d.keep = (state_q == S_QUERY) || ((ptr_q != edge_q) && (ptr_q != edge_nx));
		issue_d.last = ({1'b0, ptr_q} == (count_q - CNT_W'(1)));
		issue_d.idx  = ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
		end else begin
			issue_q <= issue_d;
		end
	end

	assign ux1 = qmode_q ? rd.ax : ex1_q;
	assign uy1 = qmode_q ? rd.ay : ey1_q;
	assign ux2 = qmode_q ? rd.bx : ex2_q;
	assign uy2 = qmode_q ? rd.by : ey2_q;
	assign ux3 = qmode_q ? px_q  : rd.ax;
	assign uy3 = qmode_q ? py_q  : rd.ay;

	cpc_side_unit u_side (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (issue_q),
		.x1      (ux1),
		.y1      (uy1),
		.x2      (ux2),
		.y2      (uy2),
		.x3      (ux3),
		.y3      (uy3),
		.tag_out (res_tag),
		.side    (res_side)
	);

	// fold returning side tests into the edge code or the query verdict
	always_comb begin
		code_n  = code_q;
		fresh_n = fresh_q;
		if (res_tag.vld && res_tag.keep && (res_side != SIDE_ON)) begin
			if (fresh_q) begin
				code_n  = res_side;
				fresh_n = 1'b0;
			end else if (res_side != code_q) begin
				code_n = SIDE_NONE;
			end
		end
		fail_n = fail_q || (res_tag.vld && (res_side != SIDE_ON) &&
				(res_side != edge_side[res_tag.idx]));
		ok_n     = ok_q && (code_n != SIDE_NONE);
		res_last = res_tag.vld && res_tag.last;
	end

	always_comb begin
		es_we   = 1'b0;
		es_addr = count_q[IDX_W-1:0];
		es_data = SIDE_NONE;
		if (wr.en) begin
			es_we = 1'b1;
		end else if ((state_q == S_DRAIN) && res_last) begin
			es_we   = 1'b1;
			es_addr = edge_q;
			es_data = code_n;
		end
	end

	always_ff @(posedge clk) begin
		if (es_we) begin
			edge_side[es_addr] <= es_data;
		end
	end

	// edge endpoints and query point
	always_ff @(posedge clk) begin
		if (state_q == S_EDGE_LD) begin
			ex1_q <= rd.ax;
			ey1_q <= rd.ay;
			ex2_q <= rd.bx;
			ey2_q <= rd.by;
		end
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			convex_q <= 1'b0;
			done_q   <= 1'b0;
			answer_q <= 1'b0;
			full_q   <= 1'b0;
			edge_q   <= '0;
			ptr_q    <= '0;
			ok_q     <= 1'b0;
			fresh_q  <= 1'b1;
			fail_q   <= 1'b0;
			qmode_q  <= 1'b0;
			code_q   <= SIDE_NONE;
		end else begin
			done_q  <= 1'b0;
			code_q  <= code_n;
			fresh_q <= fresh_n;
			fail_q  <= fail_n;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						full_q <= 1'b0;
						case (action)
							ACT_CLEAR: begin
								count_q  <= '0;
								convex_q <= 1'b0;
								answer_q <= 1'b1;
								done_q   <= 1'b1;
							end
							ACT_ADD: begin
								if (store_full) begin
									answer_q <= 1'b0;
									full_q   <= 1'b1;
									done_q   <= 1'b1;
								end else begin
									count_q <= count_inc;
									if (!recheck) begin
										answer_q <= 1'b1;
										done_q   <= 1'b1;
									end else if (count_inc < CNT_W'(3)) begin
										// too few vertices: every edge already undetermined
										convex_q <= 1'b0;
										answer_q <= 1'b0;
										done_q   <= 1'b1;
									end else begin
										edge_q  <= '0;
										ok_q    <= 1'b1;
										qmode_q <= 1'b0;
										state_q <= S_EDGE_RD;
									end
								end
							end
							ACT_QUERY: begin
								if (!convex_q || (count_q == '0)) begin
									answer_q <= 1'b0;
									done_q   <= 1'b1;
								end else begin
									ptr_q   <= '0;
									fail_q  <= 1'b0;
									qmode_q <= 1'b1;
									state_q <= S_QUERY;
								end
							end
							default: begin
								answer_q <= 1'b0;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				S_EDGE_RD: begin
					state_q <= S_EDGE_LD;
				end
				S_EDGE_LD: begin
					ptr_q   <= '0;
					fresh_q <= 1'b1;
					code_q  <= SIDE_NONE;
					state_q <= S_STREAM;
				end
				S_STREAM: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (issue_d.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (res_last) begin
						if ({1'b0, edge_q} == (count_q - CNT_W'(1))) begin
							convex_q <= ok_n;
							answer_q <= ok_n;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							ok_q    <= ok_n;
							edge_q  <= edge_q + IDX_W'(1);
							state_q <= S_EDGE_RD;
						end
					end
				end
				S_QUERY: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (issue_d.last) begin
						state_q <= S_QDRAIN;
					end
				end
				S_QDRAIN: begin
					if (res_last) begin
						answer_q <= !fail_n;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign answer       = answer_q;
	assign full_error   = full_q;
	assign convex       = convex_q;
	assign vertex_count = count_q;

endmodule

// ===== hdl/cpc_checker.sv =====
// port-level checks for the convex polygon containment block, bound to the top level
// depends on cpc_pkg and convex_polygon_containment_defines.svh
`include "convex_polygon_containment_defines.svh"

module cpc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic                              answer,
	input logic                              convex,
	input logic [cpc_pkg::CNT_W-1:0]         vertex_count,
	input logic                              full_error
);
	import cpc_pkg::*;

	// an accepted beat is either answered next cycle or keeps the block busy
	`CPC_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted beat lost")
	`CPC_ASSERT_NOW(a_done_not_busy, done, !busy, "result strobe while busy")
	`CPC_ASSERT_NOW(a_full_count, done && full_error, vertex_count == CNT_W'(MAX_VERTICES),
		"full error with free room")
	`CPC_ASSERT_NOW(a_full_answer, done && full_error, !answer && (convex == $past(convex)),
		"refused add changed state")

endmodule

bind convex_polygon_containment cpc_checker u_cpc_checker (.*);

// ===== tb/convex_polygon_containment_tb.sv =====
// self-checking testbench for the convex polygon containment block
// depends on cpc_pkg and convex_polygon_containment; predicts every beat in place
module convex_polygon_containment_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpc_pkg::*;

	localparam int      LIMIT_CYCLES = 1_500_000;
	localparam int      RANDOM_BEATS = 850;
	localparam int      MAX_REPORTS  = 30;
	localparam action_t ACT_UNUSED   = 2'd3;

	typedef struct {
		logic             answer;
		logic             convex;
		logic [CNT_W-1:0] vertex_count;
		logic             full_error;
	} outcome_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [1:0]             action = ACT_CLEAR;
	logic [COORD_WIDTH-1:0] coord_x = '0;
	logic [COORD_WIDTH-1:0] coord_y = '0;
	logic                   recheck = 1'b0;
	logic                   busy;
	logic                   done;
	logic                   answer;
	logic                   convex;
	logic [CNT_W-1:0]       vertex_count;
	logic                   full_error;

	// polygon as the block should hold it
	longint   poly_x [MAX_VERTICES];
	longint   poly_y [MAX_VERTICES];
	side_t    poly_side [MAX_VERTICES];
	bit       poly_convex;
	int       poly_count;

	outcome_t pending_q [$];
	int       errors;
	int       cycles;
	int       idle_pct;
	int       random_beats;
	int       results_seen;
	int       n_queries, n_inside, n_convex_adds, n_refused;

	convex_polygon_containment dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.recheck         (recheck),
		.done            (done),
		.answer          (answer),
		.convex          (convex),
		.vertex_count    (vertex_count),
		.full_error      (full_error)
	);

	always #2 clk = ~clk;

	// exact cross-product sign, vertical and zero-length edges handled apart
	function automatic side_t side_of(longint x1, longint y1, longint x2, longint y2,
			longint x3, longint y3);
		longint run, rise, d;
		if (x1 == x2) begin
			if (y1 == y2) return SIDE_ON;
			if (x3 > x1) return SIDE_BELOW;
			if (x3 < x1) return SIDE_ABOVE;
			return SIDE_ON;
		end
		run  = x2 - x1;
		rise = y2 - y1;
		d    = rise * (x3 - x1) - (y3 - y1) * run;
		if (run < 0) d = -d;
		if (d > 0) return SIDE_BELOW;
		if (d < 0) return SIDE_ABOVE;
		return SIDE_ON;
	endfunction

	function automatic int following(int i);
		return (i + 1 >= poly_count) ? 0 : i + 1;
	endfunction

	function automatic void resolve_edge(int i);
		int    k;
		bit    fresh;
		side_t code, s;
		fresh = 1'b1;
		code  = SIDE_NONE;
		if (poly_count <= 2) begin
			poly_side[i] = SIDE_NONE;
			return;
		end
		k = following(i);
		for (int j = 0; j < poly_count; j++) begin
			if (j == i || j == k) continue;
			s = side_of(poly_x[i], poly_y[i], poly_x[k], poly_y[k], poly_x[j], poly_y[j]);
			if (s == SIDE_ON) continue;
			if (fresh) begin
				code  = s;
				fresh = 1'b0;
			end else if (s != code) begin
				code = SIDE_NONE;
			end
		end
		poly_side[i] = code;
	endfunction

	function automatic void resolve_polygon();
		bit ok;
		for (int i = 0; i < poly_count; i++) resolve_edge(i);
		ok = poly_count >= 3;
		for (int i = 0; i < poly_count; i++)
			if (poly_side[i] == SIDE_NONE) ok = 1'b0;
		poly_convex = ok;
	endfunction

	function automatic bit encloses(longint x, longint y);
		side_t s;
		int    k;
		if (!poly_convex || poly_count == 0) return 1'b0;
		for (int i = 0; i < poly_count; i++) begin
			k = following(i);
			s = side_of(poly_x[i], poly_y[i], poly_x[k], poly_y[k], x, y);
			if (s != SIDE_ON && s != poly_side[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// advances the polygon by one beat and returns what the block should answer
	function automatic outcome_t apply_beat(action_t act, coord_t x, coord_t y, logic chk);
		outcome_t r;
		r.answer     = 1'b0;
		r.full_error = 1'b0;
		case (act)
			ACT_CLEAR: begin
				poly_count  = 0;
				poly_convex = 1'b0;
				r.answer    = 1'b1;
			end
			ACT_ADD: begin
				if (poly_count >= MAX_VERTICES) begin
					r.full_error = 1'b1;
					n_refused++;
				end else begin
					poly_x[poly_count]    = longint'(x);
					poly_y[poly_count]    = longint'(y);
					poly_side[poly_count] = SIDE_NONE;
					poly_count++;
					if (chk) begin
						resolve_polygon();
						r.answer = poly_convex;
						if (poly_convex) n_convex_adds++;
					end else begin
						r.answer = 1'b1;
					end
				end
			end
			ACT_QUERY: begin
				r.answer = encloses(longint'(x), longint'(y));
				n_queries++;
				if (r.answer) n_inside++;
			end
			default: ;
		endcase
		r.convex       = poly_convex;
		r.vertex_count = CNT_W'(poly_count);
		return r;
	endfunction

	task automatic send_beat(action_t act, coord_t x, coord_t y, logic chk);
		outcome_t expected;
		start   <= 1'b1;
		action  <= act;
		coord_x <= x;
		coord_y <= y;
		recheck <= chk;
		do @(posedge clk); while (busy);
		expected  = apply_beat(act, x, y, chk);
		pending_q = {pending_q, expected};
		if (act != ACT_UNUSED) random_beats++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report(string what, int want, int got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// result side: one beat per done strobe, cannot be stalled
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%t unexpected result beat: expected none, got answer %0d",
						$time, answer);
			end else begin
				want = pending_q.pop_front();
				if (answer !== want.answer) report("answer", want.answer, answer);
				if (convex !== want.convex) report("convex", want.convex, convex);
				if (vertex_count !== want.vertex_count)
					report("vertex_count", want.vertex_count, vertex_count);
				if (full_error !== want.full_error)
					report("full_error", want.full_error, full_error);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%t timeout with %0d results outstanding", $time, pending_q.size());
			$display("** convex_polygon_containment: FAILED **");
			$finish;
		end
	end

	task automatic test_clear_and_unused();
		send_beat(ACT_CLEAR, 16'sd0, 16'sd0, 1'b0);
		send_beat(ACT_QUERY, 16'sd0, 16'sd0, 1'b1);
		send_beat(ACT_UNUSED, -16'sd1, -16'sd1, 1'b1);
	endtask

	// axis-aligned square gives vertical edges; only the last add is checked
	task automatic test_square();
		send_beat(ACT_ADD, -16'sd100, -16'sd100, 1'b0);
		send_beat(ACT_ADD, 16'sd100, -16'sd100, 1'b0);
		send_beat(ACT_ADD, 16'sd100, 16'sd100, 1'b0);
		send_beat(ACT_ADD, -16'sd100, 16'sd100, 1'b1);
		send_beat(ACT_QUERY, 16'sd0, 16'sd0, 1'b0);
		send_beat(ACT_QUERY, 16'sd100, 16'sd37, 1'b0);
		send_beat(ACT_QUERY, -16'sd101, 16'sd0, 1'b0);
	endtask

	// repeated vertex makes a zero-length edge, so the shape never counts as convex
	task automatic test_degenerate_edges();
		send_beat(ACT_CLEAR, 16'sd0, 16'sd0, 1'b0);
		send_beat(ACT_ADD, 16'sd5, 16'sd5, 1'b1);
		send_beat(ACT_ADD, 16'sd5, 16'sd5, 1'b1);
		send_beat(ACT_ADD, 16'sd5, 16'sd9, 1'b1);
		send_beat(ACT_QUERY, 16'sd5, 16'sd7, 1'b0);
	endtask

	task automatic test_extreme_coords();
		send_beat(ACT_CLEAR, 16'sd0, 16'sd0, 1'b0);
		send_beat(ACT_ADD, -16'sd32768, -16'sd32768, 1'b0);
		send_beat(ACT_ADD, 16'sd32767, -16'sd32768, 1'b0);
		send_beat(ACT_ADD, 16'sd32767, 16'sd32767, 1'b1);
		send_beat(ACT_QUERY, 16'sd0, 16'sd0, 1'b0);
		send_beat(ACT_QUERY, 16'sd32767, 16'sd0, 1'b0);
		send_beat(ACT_QUERY, -16'sd32768, 16'sd32767, 1'b0);
	endtask

	// fills the store on top of the triangle, then one add too many
	task automatic test_full_store();
		for (int i = 0; i < MAX_VERTICES - 3; i++)
			send_beat(ACT_ADD, coord_t'(1000 * i), coord_t'(-500 * i),
				i == MAX_VERTICES - 4);
		send_beat(ACT_ADD, 16'sd1, 16'sd2, 1'b1);
		send_beat(ACT_QUERY, 16'sd1, 16'sd2, 1'b0);
	endtask

	// vertices on a circle in angle order, so most shapes are convex
	task automatic build_polygon();
		int  k, lim, cx, cy, r, px, py, pick, q;
		real ang [18];
		real tmp;
		bit  flip;
		k = ($urandom_range(99) < 80) ? $urandom_range(3, 8) :
			($urandom_range(99) < 75) ? $urandom_range(9, 16) : $urandom_range(17, 18);
		cx = $urandom_range(60000) - 30000;
		cy = $urandom_range(60000) - 30000;
		lim = 32700 - (((cx < 0) ? -cx : cx) > ((cy < 0) ? -cy : cy) ?
			((cx < 0) ? -cx : cx) : ((cy < 0) ? -cy : cy));
		r = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(10, lim);
		for (int i = 0; i < k; i++) begin
			ang[i] = $urandom_range(62831) / 10000.0;
			for (int j = i; j > 0 && ang[j] < ang[j-1]; j--) begin
				tmp = ang[j]; ang[j] = ang[j-1]; ang[j-1] = tmp;
			end
		end
		flip = $urandom_range(1);
		if ($urandom_range(9) != 0) send_beat(ACT_CLEAR, coord_t'($urandom), coord_t'($urandom),
			1'($urandom));
		for (int i = 0; i < k; i++) begin
			tmp = flip ? ang[k-1-i] : ang[i];
			if (i > 0 && $urandom_range(19) == 0) begin
				// repeat the previous vertex
			end else begin
				px = cx + int'(r * $cos(tmp));
				py = cy + int'(r * $sin(tmp));
			end
			send_beat(ACT_ADD, coord_t'(px), coord_t'(py),
				(i == k - 1) ? ($urandom_range(9) != 0) : ($urandom_range(7) == 0));
		end
		q = $urandom_range(2, 8);
		for (int i = 0; i < q; i++) begin
			pick = $urandom_range(poly_count > 0 ? poly_count - 1 : 0);
			case ($urandom_range(4))
				0: send_beat(ACT_QUERY, coord_t'(poly_x[pick]), coord_t'(poly_y[pick]), 1'b0);
				1: send_beat(ACT_QUERY,
					coord_t'((poly_x[pick] + poly_x[following(pick)]) / 2),
					coord_t'((poly_y[pick] + poly_y[following(pick)]) / 2), 1'b0);
				2: send_beat(ACT_QUERY, coord_t'(cx), coord_t'(cy), 1'($urandom));
				3: send_beat(ACT_QUERY, coord_t'($urandom), coord_t'($urandom), 1'($urandom));
				default: send_beat(ACT_QUERY,
					coord_t'(cx + int'($urandom_range(2 * r + 4)) - r - 2),
					coord_t'(cy + int'($urandom_range(2 * r + 4)) - r - 2), 1'b0);
			endcase
		end
	endtask

	task automatic test_random_polygons();
		int phase;
		phase = 0;
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			if (random_beats * 3 / RANDOM_BEATS != phase) begin
				phase = random_beats * 3 / RANDOM_BEATS;
				idle_pct = (phase == 1) ? 58 : 0;
				drain();
			end
			if ($urandom_range(9) == 0)
				send_beat(action_t'($urandom_range(3)), coord_t'($urandom),
					coord_t'($urandom), 1'($urandom));
			else
				build_polygon();
		end
	endtask

	initial begin
		idle_pct = 38;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear_and_unused();
		test_square();
		test_degenerate_edges();
		test_extreme_coords();
		test_full_store();
		drain();
		test_random_polygons();
		drain();
		$display("covered %0d result beats: %0d queries (%0d inside), %0d convex adds,",
			results_seen, n_queries, n_inside, n_convex_adds);
		$display("%0d refused adds, three idling phases, %0d mismatches", n_refused, errors);
		if (errors == 0) begin
			$display("** convex_polygon_containment: PASSED **");
		end else begin
			$display("** convex_polygon_containment: FAILED **");
		end
		$finish;
	end

endmodule
